// File: hdl/tdpt_pkg.sv
package tdpt_pkg;

    // Width of the candidate and tested_value fields on the ports.
    localparam int FIELD_WIDTH = 32;

    // Internal width used when sizing the field to the number datapath.
    localparam int STAGING_WIDTH = 64;

    // Odd trial divisors start here and step by two.
    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;

endpackage

// File: hdl/tdpt_divider.sv
// Restoring divider: one quotient bit per cycle, WIDTH quotient bits per division.
module tdpt_divider #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] div_reg;
    logic [WIDTH-1:0] div_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial_diff;
    logic             fits;

    // Bring down the next dividend bit and try one subtraction.
    assign shifted    = {rem_reg, quo_reg[WIDTH-1]};
    assign fits       = (shifted >= {1'b0, div_reg});
    assign trial_diff = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(WIDTH - 1);
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WIDTH-2:0], fits};
            rem_next = fits ? trial_diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/trial_division_prime_test.sv
// Trial-division primality tester. Each transaction on the input channel
// carries one candidate; exactly one transaction comes out with is_prime
// and the tested value (the candidate cut to NUMBER_WIDTH bits, then shown
// as 32 bits). Zero and one are not prime; two and three are prime; other
// even numbers are rejected at once. Odd numbers are divided by 3, 5, 7 and
// so on, on one shared restoring divider until a divisor exceeds the quotient
// (prime) or leaves no remainder (composite), so an odd candidate n needs
// about sqrt(n) / 2 divisions; even numbers and small values need none. The
// block takes one candidate at a time and holds in_stall high while it works;
// a finished result sits in the output register, so the next candidate may be
// taken while that result still waits downstream.
module trial_division_prime_test #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] candidate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_prime,
    output logic [31:0] tested_value
);

    localparam int W  = NUMBER_WIDTH;
    localparam int SW = tdpt_pkg::STAGING_WIDTH;
    localparam int FW = tdpt_pkg::FIELD_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [W-1:0]   number_reg;
    logic [W-1:0]   number_next;
    logic [W-1:0]   divisor_reg;
    logic [W-1:0]   divisor_next;
    logic           verdict_reg;
    logic           verdict_next;
    logic           div_start_reg;
    logic           div_start_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           is_prime_reg;
    logic           is_prime_next;
    logic [FW-1:0]  tested_reg;
    logic [FW-1:0]  tested_next;

    logic [SW-1:0]  cand_wide;
    logic [W-1:0]   cand_number;
    logic [SW-1:0]  number_wide;
    logic           in_take;
    logic           out_free;

    logic           div_done;
    logic [W-1:0]   div_quotient;
    logic [W-1:0]   div_remainder;

    // Size the candidate to the datapath: drop high bits or zero-extend.
    assign cand_wide   = SW'(candidate);
    assign cand_number = cand_wide[W-1:0];
    assign number_wide = SW'(number_reg);

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    tdpt_divider #(
        .WIDTH (W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (number_reg),
        .divisor   (divisor_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_comb
    begin
        state_next     = state_reg;
        number_next    = number_reg;
        divisor_next   = divisor_reg;
        verdict_next   = verdict_reg;
        div_start_next = 1'b0;
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        tested_next    = tested_reg;

        // Drop the output transaction once downstream takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    number_next  = cand_number;
                    divisor_next = W'(tdpt_pkg::FIRST_DIVISOR);
                    if (cand_number[W-1:1] == '0)
                    begin
                        // Zero and one.
                        verdict_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else if (cand_number[W-1:2] == '0)
                    begin
                        // Two and three.
                        verdict_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else if (!cand_number[0])
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        div_start_next = 1'b1;
                        state_next     = ST_DIVIDE;
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (divisor_reg > div_quotient)
                    begin
                        // Divisor passed the square root: no factor exists.
                        verdict_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else if (div_remainder == '0)
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        // Advance to the next odd divisor and divide again.
                        divisor_next   = divisor_reg + W'(tdpt_pkg::DIVISOR_STEP);
                        div_start_next = 1'b1;
                    end
                end
            end

            ST_FINISH:
            begin
                // Hold the verdict until the output register frees up.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = verdict_reg;
                    tested_next    = number_wide[FW-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            number_reg    <= '0;
            divisor_reg   <= '0;
            verdict_reg   <= 1'b0;
            is_prime_reg  <= 1'b0;
            tested_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
            number_reg    <= number_next;
            divisor_reg   <= divisor_next;
            verdict_reg   <= verdict_next;
            is_prime_reg  <= is_prime_next;
            tested_reg    <= tested_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_prime     = is_prime_reg;
    assign tested_value = tested_reg;

endmodule

// File: bench/tb_top.sv
module tb_top;

    // Width of the number datapath in the instance under test.
    localparam int NUM_W = 32;
    localparam logic [63:0] NUMBER_MASK =
        (NUM_W >= 64) ? {64{1'b1}} : ((64'd1 << NUM_W) - 64'd1);

    // Cycles to keep watching the output after the last answer has come.
    localparam int SETTLE_CYCLES = 200;

    // One answer as it should leave the block.
    typedef struct packed {
        logic        is_prime;
        logic [31:0] tested_value;
    } prime_answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] candidate;
    logic        out_valid;
    logic        out_stall;
    logic        is_prime;
    logic [31:0] tested_value;

    // Answers still owed by the block, oldest first.
    prime_answer_t pending_answers[$];

    int error_count;
    int burst_left;
    bit sender_steady;    // set: the sender never inserts gaps
    bit receiver_steady;  // set: the receiver never stalls
    int stall_hold;

    trial_division_prime_test #(
        .NUMBER_WIDTH(NUM_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .candidate   (candidate),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_prime    (is_prime),
        .tested_value(tested_value)
    );

    // Clock: period 10, high then low.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the answer for one candidate: cut it to the datapath width,
    // settle the small and even cases at once, then try odd divisors until
    // one divides evenly or its square passes the number.
    function automatic prime_answer_t predict_answer(input logic [31:0] raw);
        logic [63:0]   n;
        logic [63:0]   d;
        prime_answer_t ans;
        n = {32'd0, raw} & NUMBER_MASK;
        ans.tested_value = n[31:0];
        if (n < 64'd2)
            ans.is_prime = 1'b0;
        else if (n < 64'd4)
            ans.is_prime = 1'b1;
        else if (n[0] == 1'b0)
            ans.is_prime = 1'b0;
        else
        begin
            ans.is_prime = 1'b1;
            for (d = 64'(tdpt_pkg::FIRST_DIVISOR); d <= n / d;
                 d = d + 64'(tdpt_pkg::DIVISOR_STEP))
            begin
                if (n % d == 64'd0)
                begin
                    ans.is_prime = 1'b0;
                    break;
                end
            end
        end
        return ans;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            error_count++;
            $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h",
                     $time, what, got, want);
        end
    endtask

    // Check every accepted output transaction against the oldest owed answer.
    always @(posedge clk)
    begin
        prime_answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("unexpected result (tested_value)", tested_value, 32'd0);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (is_prime !== want.is_prime)
                    report_mismatch("is_prime", {31'd0, is_prime},
                                    {31'd0, want.is_prime});
                if (tested_value !== want.tested_value)
                    report_mismatch("tested_value", tested_value, want.tested_value);
            end
        end
    end

    // Receiver: hold stall for a random number of cycles, then draw a new
    // level. Roughly one draw in three stalls. Drop all stalls while
    // receiver_steady is set.
    always @(negedge clk)
    begin
        if (receiver_steady)
        begin
            out_stall  <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold <= $urandom_range(0, 6);
        end
    end

    // Send one candidate. Entered and left at a falling edge. The sender
    // works in bursts: when a burst runs out, drop valid for a random gap
    // (no gap while sender_steady is set) and start a new burst. Within a
    // burst valid stays high and only the payload advances.
    task automatic send_candidate(input logic [31:0] value);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap = sender_steady ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            in_valid  <= 1'b1;
            candidate <= value;
            // Wait for the transaction; in_stall is read before the edge updates it.
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            pending_answers.insert(pending_answers.size(), predict_answer(value));
            @(negedge clk);
        end
    endtask

    // Hold the input idle until every owed answer has come out.
    task automatic drain_answers();
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            while (pending_answers.size() != 0)
                @(negedge clk);
        end
    endtask

    // Zero, one, two, three and the first few numbers above them.
    task automatic test_small_values();
        int v;
        begin
            for (v = 0; v <= 7; v++)
                send_candidate(v);
        end
    endtask

    // All ones, top bit alone, alternating patterns: every one of these has
    // a small factor, so the block answers quickly.
    task automatic test_field_extremes();
        begin
            send_candidate(32'hFFFF_FFFF);
            send_candidate(32'hFFFF_FFFE);
            send_candidate(32'h8000_0000);
            send_candidate(32'h8000_0001);
            send_candidate(32'h5555_5555);
            send_candidate(32'hAAAA_AAAA);
        end
    endtask

    // Squares of primes, and 1009 squared plus two: the search must try the
    // divisor whose square equals the number, not stop just short of it.
    task automatic test_square_boundaries();
        begin
            send_candidate(32'd9);
            send_candidate(32'd25);
            send_candidate(32'd49);
            send_candidate(32'd121);
            send_candidate(32'd1018081);   // 1009 squared
            send_candidate(32'd1018083);
        end
    endtask

    // Primes that run the divider loop to its end. Drain first so these
    // start from an empty pipeline.
    task automatic test_medium_primes();
        begin
            drain_answers();
            send_candidate(32'd65521);
            send_candidate(32'd65537);
            send_candidate(32'd1048573);
        end
    endtask

    // Random mix. Keep most numbers small so primes stay cheap; full-width
    // numbers are forced to carry a small factor so they finish fast while
    // still toggling every candidate bit.
    task automatic test_random_mix(input int count);
        int          i;
        int          kind;
        int          width;
        int          factor;
        logic [31:0] v;
        begin
            for (i = 0; i < count; i++)
            begin
                // Run a stretch with no idling on either side.
                sender_steady   = (i >= 30 && i < 50);
                receiver_steady = (i >= 30 && i < 50);
                kind = $urandom_range(0, 9);
                v = $urandom;
                if (kind <= 5)
                begin
                    width = $urandom_range(1, 16);
                    v = v & ((32'd1 << width) - 32'd1);
                end
                else if (kind == 6)
                begin
                    width = $urandom_range(17, 20);
                    v = v & ((32'd1 << width) - 32'd1);
                end
                else if (kind == 7)
                begin
                    v[0] = 1'b0;
                end
                else
                begin
                    case ($urandom_range(0, 4))
                        0: factor = 3;
                        1: factor = 5;
                        2: factor = 7;
                        3: factor = 11;
                        default: factor = 13;
                    endcase
                    v = v - (v % factor);
                end
                send_candidate(v);
            end
            sender_steady   = 1'b0;
            receiver_steady = 1'b0;
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        candidate       = 32'd0;
        out_stall       = 1'b0;
        stall_hold      = 0;
        error_count     = 0;
        burst_left      = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_small_values();
        test_field_extremes();
        test_square_boundaries();
        test_medium_primes();
        test_random_mix(85);

        // Stop sending, wait for every owed answer, then watch for strays.
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** trial_division_prime_test: PASSED **");
        else
            $display("** trial_division_prime_test: FAILED **");
        $finish;
    end

    // Timeout, far beyond the slowest correct run.
    initial
    begin
        #100_000_000;
        $display("** trial_division_prime_test: FAILED **");
        $finish;
    end

endmodule
